[rtl/core/red_eye_radial_neutralizer_top_assert.svh]
// ============================================================================
// Assertion macros for the red-eye radial neutralizer
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ============================================================================
`ifndef RED_EYE_RADIAL_NEUTRALIZER_TOP_ASSERT_SVH
`define RED_EYE_RADIAL_NEUTRALIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RENR_ASSERT_ON(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define RENR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RENR_ASSERT_ON(lbl, clk, rst_n, ante, cons)
`define RENR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/renr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// renr_pkg
// Shared types, register indexes and the falloff weight table.
// ============================================================================
package renr_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MODE    = 1'd1;

	// Datapath widths.
	localparam int PCT_W     = 7;
	localparam int WGT_W     = 16;
	localparam int RED_W     = 17;
	localparam int LUT_DEPTH = 128;
	localparam int PCT_MAX   = 100;
	localparam int PCT_SCALE = 100;

	// Division by three as a multiply by a reciprocal.
	localparam int MEAN_RECIP = 683;
	localparam int MEAN_SHIFT = 11;

	typedef logic [7:0]       chan_t;
	typedef logic [PCT_W-1:0] pct_t;
	typedef logic [WGT_W-1:0] wgt_t;
	typedef logic [RED_W-1:0] red_t;

	// Redness of 1.0 in Q1.16.
	localparam red_t RED_ONE = red_t'(1) << (RED_W - 1);

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	typedef wgt_t wgt_lut_t [LUT_DEPTH];
	typedef int falloff_t [11];

	localparam falloff_t FALLOFF = '{100, 95, 90, 83, 77, 69, 58, 47, 36, 23, 9};

	// Weight in Q0.16 for each distance percent: interpolated falloff times 0.9.
	function automatic wgt_lut_t calc_wgt_lut();
		wgt_lut_t lut;
		int pc;
		int q;
		int m;
		int prof;
		for (int p = 0; p < LUT_DEPTH; p++) begin
			pc = (p > PCT_MAX) ? PCT_MAX : p;
			q = pc / 10;
			m = pc % 10;
			prof = FALLOFF[q];
			if (m != 0 && q < 10) begin
				prof = FALLOFF[q] - ((FALLOFF[q] - FALLOFF[q + 1]) * m) / 10;
			end
			lut[p] = WGT_W'((prof * 589824) / 1000);
		end
		return lut;
	endfunction

	localparam wgt_lut_t WGT_LUT = calc_wgt_lut();

endpackage

[rtl/core/renr_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// renr_if
// Valid/ready channels for incoming pixels and corrected results.
// ============================================================================

// Pixel channel.
interface renr_pix_if import renr_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t pixel_red;
	chan_t pixel_green;
	chan_t pixel_blue;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

// Result channel.
interface renr_res_if import renr_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t out_red;
	chan_t out_green;
	chan_t out_blue;
	logic  patch_done;

	modport source (output valid, out_red, out_green, out_blue, patch_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, patch_done, output ready);
endinterface

[rtl/core/renr_pipe.sv]
`timescale 1ns / 1ps
// ============================================================================
// renr_pipe
// Pixel datapath: distance, pipelined dividers, weight lookup and blend.
// ============================================================================
`include "red_eye_radial_neutralizer_top_assert.svh"

module renr_pipe import renr_pkg::*; #(
	parameter int DW = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rgb_t            in_pix,
	input  logic [DW-1:0]   in_dx,
	input  logic [DW-1:0]   in_dy,
	input  logic            in_done,
	input  logic [2*DW-1:0] r2,
	input  logic            hue_mode,
	input  logic            bypass,
	output logic            out_valid,
	input  logic            out_ready,
	output rgb_t            out_pix,
	output logic            out_done
);

	localparam int R2W  = 2 * DW;
	localparam int D2W  = 2 * DW + 1;
	localparam int NUMW = 2 * DW + 8;
	localparam int FR   = RED_W - 1;
	localparam int WN   = FR - PCT_W;

	// Item fields carried alongside the divider stages.
	typedef struct packed {
		rgb_t        pix;
		chan_t       mean;
		logic        done;
		logic        in_circle;
		logic        rzero;
		logic [9:0]  tsum;
	} carry_t;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s21, v_s22, v_s23;
	logic v_fr [FR];

	// Stage registers.
	rgb_t          pix_s1, pix_s2, pix_s3;
	logic [DW-1:0] dx_s1, dy_s1;
	logic          done_s1, done_s2, done_s3;
	logic [R2W-1:0] dx2_s2, dy2_s2;
	chan_t         rp_s2, rp_s3;
	logic [9:0]    tsum_s2, tsum_s3, sum_s2;
	logic          rzero_s2, rzero_s3;
	logic [D2W-1:0] d2_s3;
	chan_t         mean_s3;
	logic [NUMW-1:0] num_s4;
	logic [9:0]    rrem_s4;
	red_t          rquo_s4;
	carry_t        carry_s4;

	logic [9:0]    rrem_fr [FR];
	red_t          rquo_fr [FR];
	carry_t        carry_fr [FR];
	logic [NUMW-1:0] prem_pd [PCT_W];
	pct_t          pquo_pd [PCT_W];
	wgt_t          wgt_fr [WN];

	wgt_t          n_s21;
	chan_t         dif_s21 [3];
	logic          up_s21 [3];
	carry_t        carry_s21;
	chan_t         prod_s22 [3];
	logic          up_s22 [3];
	carry_t        carry_s22;

	// Combinational terms of the stages.
	chan_t      mn;
	chan_t      gp;
	chan_t      bp;
	logic       rgeq;
	logic       red_ge;
	chan_t      ch_end [3];
	chan_t      ch_s22 [3];
	chan_t      res_ch [3];
	logic [WGT_W+RED_W-1:0] wprod;

	// The whole pipe advances whenever the output register can take an item.
	assign en        = !v_s23 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s23;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s21 <= v_fr[FR-1];
			v_s22 <= v_s21;
			v_s23 <= v_s22;
		end
	end

	// Stage 1: capture the pixel and its offsets.
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= in_pix;
			dx_s1   <= in_dx;
			dy_s1   <= in_dy;
			done_s1 <= in_done;
		end
	end

	// Stage 2: squares of the offsets, grey floor removal and channel sum.
	always_comb begin
		mn   = (pix_s1.green < pix_s1.blue) ? pix_s1.green : pix_s1.blue;
		gp   = pix_s1.green - mn;
		bp   = pix_s1.blue - mn;
		rgeq = pix_s1.red >= mn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2   <= R2W'(dx_s1) * R2W'(dx_s1);
			dy2_s2   <= R2W'(dy_s1) * R2W'(dy_s1);
			rp_s2    <= pix_s1.red - mn;
			tsum_s2  <= 10'(pix_s1.red - mn) + 10'(gp) + 10'(bp);
			rzero_s2 <= !rgeq;
			sum_s2   <= 10'(pix_s1.red) + 10'(pix_s1.green) + 10'(pix_s1.blue);
			pix_s2   <= pix_s1;
			done_s2  <= done_s1;
		end
	end

	// Stage 3: squared distance and channel mean.
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3    <= D2W'(dx2_s2) + D2W'(dy2_s2);
			mean_s3  <= 8'((20'(sum_s2) * 20'(MEAN_RECIP)) >> MEAN_SHIFT);
			rzero_s3 <= rzero_s2 || (tsum_s2 == 10'd0);
			rp_s3    <= rp_s2;
			tsum_s3  <= tsum_s2;
			pix_s3   <= pix_s2;
			done_s3  <= done_s2;
		end
	end

	// Stage 4: circle test, percent numerator and the integer bit of redness.
	assign red_ge = {2'b00, rp_s3} >= tsum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4             <= NUMW'(d2_s3) * NUMW'(PCT_SCALE);
			rrem_s4            <= red_ge ? 10'(rp_s3) - tsum_s3 : 10'(rp_s3);
			rquo_s4            <= red_t'(red_ge);
			carry_s4.pix       <= pix_s3;
			carry_s4.mean      <= mean_s3;
			carry_s4.done      <= done_s3;
			carry_s4.in_circle <= d2_s3 <= D2W'(r2);
			carry_s4.rzero     <= rzero_s3;
			carry_s4.tsum      <= tsum_s3;
		end
	end

	// Redness divider: one fraction bit per stage, stages 5 to 20.
	for (genvar k = 0; k < FR; k++) begin : g_red
		logic [9:0]  rem_in;
		red_t        quo_in;
		carry_t      car_in;
		logic        v_in;
		logic [10:0] rem_dbl;
		logic        ge;

		if (k == 0) begin : g_head
			assign rem_in = rrem_s4;
			assign quo_in = rquo_s4;
			assign car_in = carry_s4;
			assign v_in   = v_s4;
		end else begin : g_body
			assign rem_in = rrem_fr[k-1];
			assign quo_in = rquo_fr[k-1];
			assign car_in = carry_fr[k-1];
			assign v_in   = v_fr[k-1];
		end

		assign rem_dbl = {rem_in, 1'b0};
		assign ge      = rem_dbl >= {1'b0, car_in.tsum};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_fr[k] <= 1'b0;
			end else if (en) begin
				v_fr[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rrem_fr[k]  <= ge ? 10'(rem_dbl - {1'b0, car_in.tsum}) : rem_dbl[9:0];
				rquo_fr[k]  <= {quo_in[RED_W-2:0], ge};
				carry_fr[k] <= car_in;
			end
		end

		// Weight lookup once the percent is known, then carried along.
		if (k == PCT_W) begin : g_wload
			always_ff @(posedge clk) begin
				if (en) begin
					wgt_fr[0] <= WGT_LUT[pquo_pd[PCT_W-1]];
				end
			end
		end else if (k > PCT_W) begin : g_wcarry
			always_ff @(posedge clk) begin
				if (en) begin
					wgt_fr[k-PCT_W] <= wgt_fr[k-PCT_W-1];
				end
			end
		end
	end

	// Percent divider: one quotient bit per stage, stages 5 to 11.
	for (genvar j = 0; j < PCT_W; j++) begin : g_pct
		logic [NUMW-1:0] rem_in;
		pct_t            quo_in;
		logic [NUMW-1:0] dsh;
		logic            ge;

		if (j == 0) begin : g_head
			assign rem_in = num_s4;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = prem_pd[j-1];
			assign quo_in = pquo_pd[j-1];
		end

		assign dsh = NUMW'(r2) << (PCT_W - 1 - j);
		assign ge  = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				prem_pd[j] <= ge ? rem_in - dsh : rem_in;
				pquo_pd[j] <= quo_in | (pct_t'(ge) << (PCT_W - 1 - j));
			end
		end
	end

	// Stage 21: final strength and per-channel distance to the mean.
	assign ch_end[0] = carry_fr[FR-1].pix.red;
	assign ch_end[1] = carry_fr[FR-1].pix.green;
	assign ch_end[2] = carry_fr[FR-1].pix.blue;
	assign wprod     = (WGT_W+RED_W)'(wgt_fr[WN-1]) * (WGT_W+RED_W)'(rquo_fr[FR-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!hue_mode) begin
				n_s21 <= wgt_fr[WN-1];
			end else if (carry_fr[FR-1].rzero) begin
				n_s21 <= '0;
			end else begin
				n_s21 <= WGT_W'(wprod >> 16);
			end
			for (int i = 0; i < 3; i++) begin
				up_s21[i]  <= carry_fr[FR-1].mean >= ch_end[i];
				dif_s21[i] <= (carry_fr[FR-1].mean >= ch_end[i]) ?
					carry_fr[FR-1].mean - ch_end[i] : ch_end[i] - carry_fr[FR-1].mean;
			end
			carry_s21 <= carry_fr[FR-1];
		end
	end

	// Stage 22: step size per channel, truncated toward zero.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s22[i] <= 8'((24'(dif_s21[i]) * 24'(n_s21)) >> 16);
				up_s22[i]   <= up_s21[i];
			end
			carry_s22 <= carry_s21;
		end
	end

	// Stage 23: apply the step, or pass the pixel outside the circle or in bypass.
	assign ch_s22[0] = carry_s22.pix.red;
	assign ch_s22[1] = carry_s22.pix.green;
	assign ch_s22[2] = carry_s22.pix.blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bypass || !carry_s22.in_circle) begin
				res_ch[i] = ch_s22[i];
			end else if (up_s22[i]) begin
				res_ch[i] = ch_s22[i] + prod_s22[i];
			end else begin
				res_ch[i] = ch_s22[i] - prod_s22[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pix.red   <= res_ch[0];
			out_pix.green <= res_ch[1];
			out_pix.blue  <= res_ch[2];
			out_done      <= carry_s22.done;
		end
	end

	// A pixel inside the circle of a real patch yields a percent of at most one hundred.
	`RENR_ASSERT_ON(a_pct_bound, clk, arst_n, !bypass && v_fr[PCT_W-1] && carry_fr[PCT_W-1].in_circle, pquo_pd[PCT_W-1] <= pct_t'(PCT_MAX))
	// Redness never exceeds one.
	`RENR_ASSERT_ON(a_red_bound, clk, arst_n, v_fr[FR-1] && !carry_fr[FR-1].rzero, rquo_fr[FR-1] <= RED_ONE)
	// The blend strength never exceeds the center weight.
	`RENR_ASSERT_ON(a_wgt_bound, clk, arst_n, v_s21, n_s21 <= WGT_LUT[0])

endmodule

[rtl/core/red_eye_radial_neutralizer_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// red_eye_radial_neutralizer_top
// Pulls pixels inside the circle of a square patch toward grey by a radial
// falloff weight, optionally scaled by each pixel's redness.
// ============================================================================
//
//  Channel   Direction  Contents
//  pix_in    in         pixel_red, pixel_green, pixel_blue
//  res_out   out        out_red, out_green, out_blue, patch_done
//  cfg_*     in         square_size (index 0), hue_mode (index 1)
//
// One pixel is taken every cycle unless the result side stalls; the pipeline
// depth is set by the 16-stage redness divider.
// Reset clears the position counters, the pipeline valid bits and sets the
// side to one with redness scaling on.
// When the result is not taken the whole pipeline holds and pix_in.ready drops.
//
`include "red_eye_radial_neutralizer_top_assert.svh"

module red_eye_radial_neutralizer_top import renr_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	renr_pix_if.sink              pix_in,
	renr_res_if.source            res_out
);

	localparam int CW  = $clog2(MAX_SIDE);
	localparam int SW  = CW + 1;
	localparam int R2W = 2 * CW;

	// Configuration and derived geometry.
	logic [SW-1:0]  side_q;
	logic [CW-1:0]  ctr_q;
	logic           even_q;
	logic [R2W-1:0] r2_q;
	logic           mode_q;
	logic           bypass_q;

	logic [31:0]    wr_side;
	logic [SW-1:0]  side_nxt;
	logic [CW-1:0]  ctr_nxt;
	logic [R2W-1:0] ctr_ext;

	// Position counters.
	logic [CW-1:0]  col_q;
	logic [CW-1:0]  row_q;
	logic           last_col;
	logic           last_row;
	logic           done;
	logic [CW-1:0]  dx;
	logic [CW-1:0]  dy;
	logic           acc;

	rgb_t           pix;
	rgb_t           res_pix;
	logic           size_wr;

	// Side clamped to one..MAX_SIDE and its circle geometry.
	always_comb begin
		if (cfg_wdata == '0) begin
			wr_side = 32'd1;
		end else if (32'(cfg_wdata) > 32'(MAX_SIDE)) begin
			wr_side = 32'(MAX_SIDE);
		end else begin
			wr_side = 32'(cfg_wdata);
		end
		side_nxt = SW'(wr_side);
		ctr_nxt  = CW'(side_nxt >> 1);
		ctr_ext  = R2W'(ctr_nxt);
	end

	assign size_wr = cfg_wr_en && (cfg_index == REG_SQUARE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= SW'(1);
			ctr_q    <= '0;
			even_q   <= 1'b0;
			r2_q     <= '0;
			mode_q   <= 1'b1;
			bypass_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SQUARE_SIZE: begin
					side_q   <= side_nxt;
					ctr_q    <= ctr_nxt;
					even_q   <= !side_nxt[0];
					r2_q     <= ctr_ext * ctr_ext + R2W'(!side_nxt[0]);
					bypass_q <= side_nxt == SW'(1);
				end
				REG_HUE_MODE: begin
					mode_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Raster position and offsets from the center.
	assign acc      = pix_in.valid && pix_in.ready;
	assign last_col = SW'(col_q) >= side_q - SW'(1);
	assign last_row = SW'(row_q) >= side_q - SW'(1);
	assign done     = last_col && last_row;

	always_comb begin
		if (col_q >= ctr_q) begin
			dx = col_q - ctr_q + CW'(even_q);
		end else begin
			dx = ctr_q - col_q;
		end
		if (row_q >= ctr_q) begin
			dy = row_q - ctr_q + CW'(even_q);
		end else begin
			dy = ctr_q - row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (size_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Datapath.
	assign pix.red   = pix_in.pixel_red;
	assign pix.green = pix_in.pixel_green;
	assign pix.blue  = pix_in.pixel_blue;

	renr_pipe #(
		.DW(CW)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.in_pix   (pix),
		.in_dx    (dx),
		.in_dy    (dy),
		.in_done  (done),
		.r2       (r2_q),
		.hue_mode (mode_q),
		.bypass   (bypass_q),
		.out_valid(res_out.valid),
		.out_ready(res_out.ready),
		.out_pix  (res_pix),
		.out_done (res_out.patch_done)
	);

	assign res_out.out_red   = res_pix.red;
	assign res_out.out_green = res_pix.green;
	assign res_out.out_blue  = res_pix.blue;

	// Counters stay inside the patch.
	`RENR_ASSERT_ON(a_col_range, clk, arst_n, 1'b1, SW'(col_q) < side_q)
	`RENR_ASSERT_ON(a_row_range, clk, arst_n, 1'b1, SW'(row_q) < side_q)
	// The last pixel of a patch returns the position to the origin.
	`RENR_ASSERT_NEXT(a_patch_wrap, clk, arst_n, acc && done, (col_q == '0) && (row_q == '0))

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Red-eye radial neutralizer testbench
// Streams square patches of pixels through the block under several side and
// hue settings. Each accepted pixel is run through an in-bench model of the
// radial falloff and redness weighting. Every result transaction is compared
// field by field with the oldest predicted pixel. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import renr_pkg::*;

	localparam int SIDE_LIMIT  = 1024;
	localparam int LATENCY     = 23;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  done;
	} corrected_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	renr_pix_if pix ();
	renr_res_if res ();

	red_eye_radial_neutralizer_top #(.MAX_SIDE(SIDE_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_in(pix),
		.res_out(res)
	);

	// Pending pixels and predicted results.
	rgb_t       pixel_queue[$];
	corrected_t corrected_queue[$];

	// Model copy of registers and position counters.
	int unsigned side_reg;
	int unsigned mode_reg;
	int unsigned col_pos;
	int unsigned row_pos;

	int unsigned falloff_tab[11] = '{100, 95, 90, 83, 77, 69, 58, 47, 36, 23, 9};

	int errors;
	int cycles;
	int send_idle;
	int recv_idle;
	int hold_left;
	bit hold_tog;
	bit hold_seen;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned offset_of(int unsigned pos, int unsigned ctr, bit even);
		if (pos >= ctr) begin
			return pos - ctr + (even ? 1 : 0);
		end
		return ctr - pos;
	endfunction

	function automatic int unsigned move_toward(int unsigned c, int unsigned mean,
			int unsigned n);
		int unsigned v;
		if (mean >= c) begin
			v = c + (((mean - c) * n) >> 16);
		end else begin
			v = c - (((c - mean) * n) >> 16);
		end
		return v & 8'hFF;
	endfunction

	// Corrects one pixel and advances the raster position.
	function automatic corrected_t neutralize(rgb_t px);
		corrected_t o;
		int unsigned s, ctr, r2, dx, dy, d2, pct, q, m, prof, n, mean, mn, t, red;
		int unsigned r, g, b;
		longint unsigned prod;
		bit even;
		r = px.red;
		g = px.green;
		b = px.blue;
		o.red = px.red;
		o.green = px.green;
		o.blue = px.blue;
		o.done = 1'b0;
		s = (side_reg == 0) ? 1 : ((side_reg > SIDE_LIMIT) ? SIDE_LIMIT : side_reg);
		if (s >= 2) begin
			even = (s % 2) == 0;
			ctr = s / 2;
			r2 = ctr * ctr + (even ? 1 : 0);
			dx = offset_of(col_pos, ctr, even);
			dy = offset_of(row_pos, ctr, even);
			d2 = dx * dx + dy * dy;
			if (dx <= SIDE_LIMIT && dy <= SIDE_LIMIT && d2 <= r2) begin
				pct = (d2 * 100) / r2;
				if (pct > 100) pct = 100;
				q = pct / 10;
				m = pct % 10;
				prof = falloff_tab[q];
				if (m != 0 && q < 10) begin
					prof = falloff_tab[q] - ((falloff_tab[q] - falloff_tab[q + 1]) * m) / 10;
				end
				n = (prof * 589824) / 1000;
				if (mode_reg != 0) begin
					// Redness: red share after removing the green/blue minimum.
					mn = (g < b) ? g : b;
					red = 0;
					if (r >= mn) begin
						t = (r - mn) + (g - mn) + (b - mn);
						if (t != 0) red = ((r - mn) << 16) / t;
					end
					prod = longint'(n) * longint'(red);
					n = int'(prod >> 16);
				end
				mean = (r + g + b) / 3;
				o.red = move_toward(r, mean, n);
				o.green = move_toward(g, mean, n);
				o.blue = move_toward(b, mean, n);
			end
		end
		if (col_pos >= s - 1) begin
			col_pos = 0;
			if (row_pos >= s - 1) begin
				row_pos = 0;
				o.done = 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Pixel driver: holds an offered transaction until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				corrected_queue.push_back(neutralize(pixel_queue.pop_front()));
			end
			if (!(pix.valid && !pix.ready)) begin
				if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					pix.valid <= 1'b1;
					pix.pixel_red <= pixel_queue[0].red;
					pix.pixel_green <= pixel_queue[0].green;
					pix.pixel_blue <= pixel_queue[0].blue;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor and ready generation.
	always @(posedge clk) begin
		corrected_t e;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (corrected_queue.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					e = corrected_queue.pop_front();
					if (res.out_red !== e.red) report("out_red", res.out_red, e.red);
					if (res.out_green !== e.green) report("out_green", res.out_green, e.green);
					if (res.out_blue !== e.blue) report("out_blue", res.out_blue, e.blue);
					if (res.patch_done !== e.done)
						report("patch_done", res.patch_done, e.done);
				end
			end
			res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pixel_queue.size() > 0 || corrected_queue.size() > 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SQUARE_SIZE) begin
			side_reg = value & 32'h7FF;
			col_pos = 0;
			row_pos = 0;
		end else begin
			mode_reg = value & 1;
		end
		@(negedge clk);
	endtask

	function automatic rgb_t rand_pixel();
		rgb_t p;
		if ($urandom_range(1)) begin
			p.red = $urandom_range(255);
			p.green = $urandom_range(255);
			p.blue = $urandom_range(255);
		end else begin
			// Red-eye like: strong red over dim green and blue.
			p.red = $urandom_range(255, 120);
			p.green = $urandom_range(110);
			p.blue = $urandom_range(110);
		end
		return p;
	endfunction

	task automatic add_pixel(int r, int g, int b);
		rgb_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		pixel_queue.push_back(p);
	endtask

	task automatic run_patch(int unsigned side, int unsigned mode, int count);
		wait_drained();
		write_reg(REG_SQUARE_SIZE, side);
		write_reg(REG_HUE_MODE, mode);
		for (int i = 0; i < count; i++) pixel_queue.push_back(rand_pixel());
	endtask

	initial begin
		int sent;
		int side;
		int count;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		hold_left = 0;
		hold_tog = 0;
		hold_seen = 0;
		side_reg = 1;
		mode_reg = 1;
		col_pos = 0;
		row_pos = 0;
		send_idle = 26;
		recv_idle = 49;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting: side of one passes pixels unchanged.
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(255, 0, 0);
		wait_drained();
		// Side of zero behaves as one.
		write_reg(REG_SQUARE_SIZE, 0);
		write_reg(REG_HUE_MODE, 0);
		add_pixel(200, 10, 10);
		add_pixel(0, 255, 0);
		// Side of three in red mode: red below the minimum, grey, pure red, other RGB corners.
		wait_drained();
		write_reg(REG_SQUARE_SIZE, 3);
		write_reg(REG_HUE_MODE, 1);
		add_pixel(10, 50, 60);
		add_pixel(128, 128, 128);
		add_pixel(255, 0, 0);
		add_pixel(255, 255, 0);
		add_pixel(0, 255, 255);
		add_pixel(255, 0, 255);
		add_pixel(0, 0, 255);
		add_pixel(255, 255, 255);
		add_pixel(0, 0, 0);
		// Side of two, mode zero, with the zero-skipping offsets.
		run_patch(2, 0, 4);
		// Oversized side saturates; only the start of that patch is sent.
		run_patch(2047, 1, 5);
		run_patch(SIDE_LIMIT, 0, 5);

		// Receiver holds off while a larger patch is offered.
		run_patch(16, 1, 256);
		hold_tog = ~hold_tog;
		wait_drained();

		sent = 0;
		while (sent < 780) begin
			if (sent < 260) begin
				send_idle = 26;
				recv_idle = 49;
			end else if (sent < 520) begin
				send_idle = 49;
				recv_idle = 26;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case ($urandom_range(9))
				0: side = 1;
				1: side = $urandom_range(24, 13);
				default: side = $urandom_range(12, 2);
			endcase
			count = side * side;
			// Sometimes a patch is cut short before the side is rewritten.
			if ($urandom_range(5) == 0) count = $urandom_range(count, 1);
			run_patch(side, $urandom_range(1), count);
			sent += count;
		end

		wait_drained();
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
